FILE: rtl/twin_stack_shared_store_defines.svh
// Assertion macros for the twin stack shared store.
// Included by the top level; uses its clk and arst_n signals.
`ifndef TWIN_STACK_SHARED_STORE_DEFINES_SVH
`define TWIN_STACK_SHARED_STORE_DEFINES_SVH

// Same-cycle implication; the consequent may start with a fixed delay.
`define TSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tss_pkg.sv
// Shared types and constants for the twin stack shared store.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package tss_pkg;

	// Width of the capacity register and of both stack depth counters.
	localparam int CNT_W = 5;

	// Operation codes carried by func.
	typedef enum logic [1:0] {
		FN_PUSH_LO = 2'd0,
		FN_POP_LO  = 2'd1,
		FN_PUSH_HI = 2'd2,
		FN_POP_HI  = 2'd3
	} tss_func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} tss_status_t;

	// Controller states: which of the read stage and output register hold a request.
	typedef enum logic [1:0] {
		TSS_EMPTY = 2'd0,
		TSS_READ  = 2'd1,
		TSS_HOLD  = 2'd2,
		TSS_BOTH  = 2'd3
	} tss_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic advance;
		logic cfg_wr;
	} tss_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tss_ctrl.sv
// Controller for the twin stack shared store: handshakes and stage occupancy.
// Depends on tss_pkg for the state and command types.
`default_nettype none

module tss_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	output tss_pkg::tss_cmd_t  cmd
);

	tss_pkg::tss_state_t state_q;
	tss_pkg::tss_state_t state_nx;
	logic s1_occ;
	logic out_occ;
	logic s1_nx;
	logic out_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::TSS_EMPTY;
		end else begin
			state_q <= state_nx;
		end
	end

	// Outputs: decode occupancy and issue handshakes and datapath commands.
	always_comb begin
		s1_occ  = 1'b0;
		out_occ = 1'b0;
		case (state_q)
			tss_pkg::TSS_EMPTY: begin
				s1_occ  = 1'b0;
				out_occ = 1'b0;
			end
			tss_pkg::TSS_READ: begin
				s1_occ  = 1'b1;
				out_occ = 1'b0;
			end
			tss_pkg::TSS_HOLD: begin
				s1_occ  = 1'b0;
				out_occ = 1'b1;
			end
			tss_pkg::TSS_BOTH: begin
				s1_occ  = 1'b1;
				out_occ = 1'b1;
			end
			default: begin
				s1_occ  = 1'b0;
				out_occ = 1'b0;
			end
		endcase
		out_valid   = out_occ;
		cmd.advance = s1_occ && (!out_occ || out_ready);
		in_ready    = !s1_occ || cmd.advance;
		cmd.accept  = in_valid && in_ready;
		cfg_ready   = 1'b1;
		cmd.cfg_wr  = cfg_valid;
	end

	// Next state from the requests entering and leaving each stage.
	always_comb begin
		s1_nx  = cmd.accept || (s1_occ && !cmd.advance);
		out_nx = cmd.advance || (out_occ && !out_ready);
		case ({s1_nx, out_nx})
			2'b00:   state_nx = tss_pkg::TSS_EMPTY;
			2'b10:   state_nx = tss_pkg::TSS_READ;
			2'b01:   state_nx = tss_pkg::TSS_HOLD;
			2'b11:   state_nx = tss_pkg::TSS_BOTH;
			default: state_nx = tss_pkg::TSS_EMPTY;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/tss_dpath.sv
// Datapath for the twin stack shared store: store, stack counters, result registers.
// Depends on tss_pkg for command, operation and status types.
`default_nettype none

module tss_dpath #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tss_pkg::tss_cmd_t           cmd,
	input  wire logic [1:0]                  func,
	input  wire logic signed [31:0]          push_value,
	input  wire logic [tss_pkg::CNT_W-1:0]   cfg_data,
	output logic [1:0]                       status,
	output logic signed [31:0]               popped_value,
	output logic [tss_pkg::CNT_W-1:0]        depth_one,
	output logic [tss_pkg::CNT_W-1:0]        depth_two
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [tss_pkg::CNT_W-1:0] CAP_RESET =
		(DEPTH < 16) ? tss_pkg::CNT_W'(DEPTH) : tss_pkg::CNT_W'(16);

	logic [WORD_BITS-1:0] store_mem [DEPTH];

	logic [tss_pkg::CNT_W-1:0] cap_q;
	logic [tss_pkg::CNT_W-1:0] cnt_lo_q;
	logic [tss_pkg::CNT_W-1:0] cnt_hi_q;

	logic [tss_pkg::CNT_W:0]   used;
	logic                      full;
	logic [tss_pkg::CNT_W-1:0] idx;
	logic [ADDR_W-1:0]         addr;
	logic                      wr_en;
	logic                      rd_en;
	logic [tss_pkg::CNT_W-1:0] cnt_lo_nx;
	logic [tss_pkg::CNT_W-1:0] cnt_hi_nx;
	tss_pkg::tss_status_t      stat_nx;

	logic                      pop_ok_s1;
	tss_pkg::tss_status_t      status_s1;
	logic [tss_pkg::CNT_W-1:0] depth_one_s1;
	logic [tss_pkg::CNT_W-1:0] depth_two_s1;
	logic signed [WORD_BITS-1:0] rd_s1;
	logic signed [31:0]        rd_ext;

	tss_pkg::tss_status_t      status_q;
	logic signed [31:0]        popped_q;
	logic [tss_pkg::CNT_W-1:0] depth_one_q;
	logic [tss_pkg::CNT_W-1:0] depth_two_q;

	// Operation decode: status, store address and the new stack depths.
	// Every address used stays below the effective capacity, so below DEPTH.
	always_comb begin
		used      = {1'b0, cnt_lo_q} + {1'b0, cnt_hi_q};
		full      = used >= {1'b0, cap_q};
		stat_nx   = tss_pkg::STAT_DONE;
		idx       = cnt_lo_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		cnt_lo_nx = cnt_lo_q;
		cnt_hi_nx = cnt_hi_q;
		case (tss_pkg::tss_func_t'(func))
			tss_pkg::FN_PUSH_LO: begin
				idx = cnt_lo_q;
				if (full) begin
					stat_nx = tss_pkg::STAT_OVERFLOW;
				end else begin
					wr_en     = 1'b1;
					cnt_lo_nx = cnt_lo_q + 1'b1;
				end
			end
			tss_pkg::FN_POP_LO: begin
				idx = cnt_lo_q - 1'b1;
				if (cnt_lo_q == '0) begin
					stat_nx = tss_pkg::STAT_UNDERFLOW;
				end else begin
					rd_en     = 1'b1;
					cnt_lo_nx = cnt_lo_q - 1'b1;
				end
			end
			tss_pkg::FN_PUSH_HI: begin
				idx = cap_q - 1'b1 - cnt_hi_q;
				if (full) begin
					stat_nx = tss_pkg::STAT_OVERFLOW;
				end else begin
					wr_en     = 1'b1;
					cnt_hi_nx = cnt_hi_q + 1'b1;
				end
			end
			tss_pkg::FN_POP_HI: begin
				idx = cap_q - cnt_hi_q;
				if (cnt_hi_q == '0) begin
					stat_nx = tss_pkg::STAT_UNDERFLOW;
				end else begin
					rd_en     = 1'b1;
					cnt_hi_nx = cnt_hi_q - 1'b1;
				end
			end
			default: begin
				stat_nx = tss_pkg::STAT_DONE;
			end
		endcase
		addr = ADDR_W'(idx);
	end

	// Capacity register and stack counters; a capacity write empties both stacks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q    <= (32'(cfg_data) > DEPTH) ? tss_pkg::CNT_W'(DEPTH) : cfg_data;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else if (cmd.accept) begin
			cnt_lo_q <= cnt_lo_nx;
			cnt_hi_q <= cnt_hi_nx;
		end
	end

	// Shared store: at most one write or one registered read per request.
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en) begin
			store_mem[addr] <= WORD_BITS'(push_value);
		end
		if (cmd.accept && rd_en) begin
			rd_s1 <= store_mem[addr];
		end
	end

	// Read stage: result fields waiting for the store read data.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pop_ok_s1    <= rd_en;
			status_s1    <= stat_nx;
			depth_one_s1 <= cnt_lo_nx;
			depth_two_s1 <= cnt_hi_nx;
		end
	end

	// Sign-extend or truncate the stored word to the result width.
	assign rd_ext = 32'(rd_s1);

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			status_q    <= status_s1;
			popped_q    <= pop_ok_s1 ? rd_ext : 32'sd0;
			depth_one_q <= depth_one_s1;
			depth_two_q <= depth_two_s1;
		end
	end

	assign status       = status_q;
	assign popped_value = popped_q;
	assign depth_one    = depth_one_q;
	assign depth_two    = depth_two_q;

endmodule

`default_nettype wire

FILE: rtl/twin_stack_shared_store.sv
// Two stacks in one shared store: the low stack grows up from entry 0,
// the high stack grows down from entry capacity-1.
//
// Channels: the request channel (in_valid/in_ready) carries func and
// push_value; the result channel (out_valid/out_ready) returns status,
// popped_value and both stack depths, one result per request, in order.
// The config channel (cfg_valid/cfg_ready) writes the capacity register;
// it is always ready, saturates the value to DEPTH and empties both
// stacks. Write it only while no request is in flight.
// A request passes through the read stage, which holds the store access
// with its registered read data, and then through the output register.
// Throughput is one request per cycle while the receiver keeps up, as the
// stack counters update as a request is taken; the next sees them at once.
// When the receiver stalls, the result holds in the output register and
// one more request is taken into the read stage; then in_ready drops.
// Reset clears both stacks, sets the capacity to 16 (or DEPTH if smaller)
// and leaves the store contents undefined.
`default_nettype none
`include "twin_stack_shared_store_defines.svh"

module twin_stack_shared_store #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                func,
	input  wire logic signed [31:0]        push_value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     status,
	output logic signed [31:0]             popped_value,
	output logic [tss_pkg::CNT_W-1:0]      depth_one,
	output logic [tss_pkg::CNT_W-1:0]      depth_two,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [tss_pkg::CNT_W-1:0] cfg_data
);

	tss_pkg::tss_cmd_t cmd;

	// Handshake controller.
	tss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// Store, counters and result registers.
	tss_dpath #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.push_value   (push_value),
		.cfg_data     (cfg_data),
		.status       (status),
		.popped_value (popped_value),
		.depth_one    (depth_one),
		.depth_two    (depth_two)
	);

	// A taken request has its result on the output once it has passed the read stage and the output register.
	`TSS_ASSERT_NOW(a_result_latency, in_valid && in_ready, ##2 out_valid, "result missing")

	// Refused requests never return a word other than zero.
	`TSS_ASSERT_NOW(a_refused_zero, out_valid && (status != tss_pkg::STAT_DONE), (popped_value == 32'sd0), "refused word")

	// The two stacks together never hold more than the store.
	`TSS_ASSERT_NOW(a_depth_bound, out_valid, ((32'(depth_one) + 32'(depth_two)) <= DEPTH), "depths too big")

	// A stalled result is not lost while a new request waits behind it.
	`TSS_ASSERT_NEXT(a_stall_keeps, out_valid && !out_ready, out_valid, "stalled result dropped")

endmodule

`default_nettype wire
